// ===== src/lr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the line rasterizer.
// No dependencies.
package lr_pkg;

    localparam int COORD_W   = 16;
    localparam int DIM_W     = 13;
    localparam int MAX_DIM   = 4096;
    localparam int ADDR_W    = 24;
    localparam int COLOR_W   = 32;
    localparam int SPAN_W    = COORD_W + 1;
    localparam int NSPAN_W   = COORD_W + 2;
    localparam int ERR_W     = COORD_W + 3;
    localparam int PROD_W    = COORD_W + DIM_W + 1;
    localparam int IDX_W     = PROD_W + 1;
    localparam int TOTAL_W   = 2 * DIM_W;
    localparam int IN_DATA_W  = 4 * COORD_W + COLOR_W;
    localparam int OUT_DATA_W = ADDR_W + COLOR_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    typedef enum logic {
        t_CMD_START   = 1'b0,
        t_CMD_ADVANCE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        t_REG_WIDTH  = 1'b0,
        t_REG_HEIGHT = 1'b1
    } t_reg_idx;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ===== src/line_rasterizer.sv =====
`timescale 1ns / 1ps
// Line rasterizer: all-octant integer line stepping, one pixel per advance while busy.
// An accepted advance passes stage 1, stage 2 and the output register to the output.
// Throughput: one request per cycle unless the output stalls; the step loop closes on the
// line state registers, the row-times-width product and the bounds compare take one
// pipeline stage each. Reset (synchronous, active low) clears the line state and all stage
// valids and loads width 640, height 480.
// Depends on lr_pkg.
module line_rasterizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_x, start_y, end_x, end_y, draw_color
    input  logic [lr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_address, pixel_color
    output logic [lr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // write_enable
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [lr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lr_pkg::DIM_W-1:0]      i_cfg_data
);
    import lr_pkg::*;

    // configuration
    logic [DIM_W-1:0]   r_width, r_height;
    logic [TOTAL_W-1:0] r_total;

    // line state
    logic                      r_busy;
    logic signed [COORD_W-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [SPAN_W-1:0]         r_span_x;
    logic signed [NSPAN_W-1:0] r_nspan_y;
    logic                      r_dir_x, r_dir_y;
    logic signed [ERR_W-1:0]   r_err;
    logic [COLOR_W-1:0]        r_color;

    // stage 1: pixel coordinates
    logic                      r_s1_valid;
    logic signed [COORD_W-1:0] r_s1_x, r_s1_y;
    logic                      r_s1_last;
    logic [COLOR_W-1:0]        r_s1_color;

    // stage 2: row product
    logic                      r_s2_valid;
    logic signed [PROD_W-1:0]  r_s2_prod;
    logic signed [COORD_W-1:0] r_s2_x;
    logic                      r_s2_last;
    logic [COLOR_W-1:0]        r_s2_color;

    // output register
    logic               r_o_valid;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_we;
    logic               r_o_last;

    logic o_ready, s2_ready, s1_ready, in_accept, is_adv, s1_load;

    assign o_ready   = !r_o_valid || m_axis_tready;
    assign s2_ready  = !r_s2_valid || o_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign is_adv    = (t_cmd'(s_axis_tuser) == t_CMD_ADVANCE);
    assign s1_load   = in_accept && is_adv && r_busy;

    // start decode
    logic signed [COORD_W-1:0] in_x0, in_y0, in_x1, in_y1;
    logic [COLOR_W-1:0]        in_color;
    logic signed [SPAN_W-1:0]  dx, dy;
    logic [SPAN_W-1:0]         n_span_x, abs_dy;
    logic signed [NSPAN_W-1:0] n_nspan_y;
    logic signed [ERR_W-1:0]   n_err_start;

    assign in_x0    = s_axis_tdata[COORD_W-1:0];
    assign in_y0    = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_x1    = s_axis_tdata[3*COORD_W-1:2*COORD_W];
    assign in_y1    = s_axis_tdata[4*COORD_W-1:3*COORD_W];
    assign in_color = s_axis_tdata[IN_DATA_W-1:4*COORD_W];

    always_comb begin
        dx          = SPAN_W'(in_x1) - SPAN_W'(in_x0);
        dy          = SPAN_W'(in_y1) - SPAN_W'(in_y0);
        n_span_x    = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
        abs_dy      = dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);
        n_nspan_y   = -$signed({1'b0, abs_dy});
        n_err_start = $signed(ERR_W'({2'b00, n_span_x})) + ERR_W'(n_nspan_y);
    end

    // step decode
    logic                      fin, step_x, step_y;
    logic signed [ERR_W:0]     e2;
    logic signed [ERR_W-1:0]   n_err_step;
    logic signed [COORD_W-1:0] n_x_step, n_y_step;

    always_comb begin
        fin        = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
        e2         = {r_err, 1'b0};
        step_x     = (ERR_W+1)'(r_nspan_y) <= e2;
        step_y     = $signed((ERR_W+1)'({3'b000, r_span_x})) >= e2;
        n_err_step = r_err;
        n_x_step   = r_cur_x;
        n_y_step   = r_cur_y;
        if (step_x) begin
            n_err_step = n_err_step + ERR_W'(r_nspan_y);
            n_x_step   = r_dir_x ? r_cur_x - COORD_W'(1) : r_cur_x + COORD_W'(1);
        end
        if (step_y) begin
            n_err_step = n_err_step + $signed(ERR_W'({2'b00, r_span_x}));
            n_y_step   = r_dir_y ? r_cur_y - COORD_W'(1) : r_cur_y + COORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_total  <= TOTAL_W'(WIDTH_RESET) * TOTAL_W'(HEIGHT_RESET);
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    t_REG_WIDTH:  r_width  <= sat_dim(i_cfg_data);
                    t_REG_HEIGHT: r_height <= sat_dim(i_cfg_data);
                    default: ;
                endcase
            end
            r_total <= TOTAL_W'(r_width) * TOTAL_W'(r_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_tgt_x   <= '0;
            r_tgt_y   <= '0;
            r_span_x  <= '0;
            r_nspan_y <= '0;
            r_dir_x   <= 1'b0;
            r_dir_y   <= 1'b0;
            r_err     <= '0;
            r_color   <= '0;
        end else if (in_accept && !is_adv) begin
            r_busy    <= 1'b1;
            r_cur_x   <= in_x0;
            r_cur_y   <= in_y0;
            r_tgt_x   <= in_x1;
            r_tgt_y   <= in_y1;
            r_span_x  <= n_span_x;
            r_nspan_y <= n_nspan_y;
            r_dir_x   <= !(in_x0 < in_x1);
            r_dir_y   <= !(in_y0 < in_y1);
            r_err     <= n_err_start;
            r_color   <= in_color;
        end else if (s1_load) begin
            if (fin) begin
                r_busy <= 1'b0;
            end else begin
                r_cur_x <= n_x_step;
                r_cur_y <= n_y_step;
                r_err   <= n_err_step;
            end
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_ready)
                r_s1_valid <= s1_load;
            if (s2_ready)
                r_s2_valid <= r_s1_valid;
            if (o_ready)
                r_o_valid <= r_s2_valid;
        end
    end

    // pipeline payload
    logic signed [IDX_W-1:0] idx;
    logic                    n_we;

    always_comb begin
        idx  = IDX_W'(r_s2_prod) + IDX_W'(r_s2_x);
        n_we = !idx[IDX_W-1] && ($signed(IDX_W'(r_total)) > idx);
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && s1_load) begin
            r_s1_x     <= r_cur_x;
            r_s1_y     <= r_cur_y;
            r_s1_last  <= fin;
            r_s1_color <= r_color;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_prod  <= PROD_W'(r_s1_y) * $signed({1'b0, r_width});
            r_s2_x     <= r_s1_x;
            r_s2_last  <= r_s1_last;
            r_s2_color <= r_s1_color;
        end
        if (o_ready && r_s2_valid) begin
            r_o_addr  <= n_we ? idx[ADDR_W-1:0] : '0;
            r_o_we    <= n_we;
            r_o_last  <= r_s2_last;
            r_o_color <= r_s2_color;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_color, r_o_addr};
    assign m_axis_tuser  = r_o_we;
    assign m_axis_tlast  = r_o_last;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid && r_s2_valid && r_o_valid)
        else $error("input stalled with a free pipeline stage");

    a_advance_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_load |=> r_s1_valid)
        else $error("advance while busy did not enter stage 1");

    a_idle_advance_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && is_adv && !r_busy && !r_s1_valid |=> !r_s1_valid)
        else $error("advance while idle produced a pixel");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_load && fin && !(s_axis_tvalid && s1_ready && !is_adv) |=> !r_busy)
        else $error("line still busy after its final pixel");

    a_suppressed_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_we |-> r_o_addr == '0)
        else $error("suppressed write carries a nonzero address");

endmodule
